FILE: rtl/pis_pkg.sv
// pis_pkg: widths, fixed-point constants and state types shared by the
// Poisson sampler top level and its checker.
// No dependencies.
package pis_pkg;

    // Default count limit
    localparam int unsigned MAX_COUNT_DEF = 255;

    // Port field widths
    localparam int UW      = 32;   // uniform value and rate
    localparam int TOL_W   = 16;   // tolerance register
    localparam int COUNT_W = 8;    // count output

    // Datapath: probabilities are Q0.40 carried in PW bits
    localparam int FRAC_W  = 40;
    localparam int PW      = 48;
    localparam int TGT_SHIFT = FRAC_W - UW;   // Q0.32 -> Q0.40

    // Shared multiplier: A is PW bits, B is one half of the split operand
    localparam int RATE_SPLIT = 16;           // rate split into 16/16
    localparam int SQ_SPLIT   = 20;           // Q0.40 split into 21/20
    localparam int BW         = FRAC_W - SQ_SPLIT + 1;
    localparam int PRODW      = PW + BW;
    localparam int LOW_W      = PRODW - RATE_SPLIT;

    // Final shifts of the three products
    localparam int SER_SHIFT  = 16;           // Q0.40 x Q0.32
    localparam int SQ_SHIFT   = 20;           // Q0.40 x Q0.40
    localparam int STEP_SHIFT = 12;           // Q0.40 x Q4.28

    // exp(-y) series and squarings
    localparam int SERIES_TERMS = 16;
    localparam int SQUARINGS    = 4;
    localparam int SQ_W         = $clog2(SQUARINGS);

    // Divider: DIV_STEP quotient bits per cycle
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = PW / DIV_STEP;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd4295;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_ACC,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PH_SERIES,
        PH_SQUARE,
        PH_STEP
    } t_phase;

endpackage

FILE: rtl/poisson_inversion_sampler.sv
// poisson_inversion_sampler: Poisson count by CDF inversion, one shared
// multiplier and a radix-16 divider under a small sequencer.
// Depends on pis_pkg.
//
// Takes a uniform word (Q0.32) and a mean (Q4.28) and returns one result word
// holding the sampled count and a saturation flag. exp(-rate) is built as
// exp(-rate/16) from a 16-term series, squared four times; then the CDF is
// walked: p <- p*rate/k, total <- total + p, until total reaches
// (uniform - tolerance) in Q0.40 or k reaches MAX_COUNT (saturated = 1 if still short).
// All arithmetic runs on one 48x21 multiplier (each product is taken in two
// halves, low then high) and one divider that retires 4 quotient bits a
// cycle. Each item runs the series terms, then the squarings, then one
// multiply, divide and check per CDF step. The input is ready only while
// the sequencer is idle. The result sits in an output register, so the
// next word is taken as soon as the current one is handed over, even if
// the consumer has not yet taken it. The tolerance register is written
// through its own channel, always ready, and must only change while the
// block is idle; reset value 4295 (about 1e-6).
module poisson_inversion_sampler #(
    parameter int unsigned MAX_COUNT = pis_pkg::MAX_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pis_pkg::UW-1:0]      i_uniform_value,
    input  logic [pis_pkg::UW-1:0]      i_rate,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pis_pkg::COUNT_W-1:0] o_count,
    output logic                        o_saturated,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pis_pkg::TOL_W-1:0]   i_cfg_tolerance
);
    import pis_pkg::*;

    // k counts both series terms and CDF steps
    localparam int CW  = $clog2(MAX_COUNT + 1);
    localparam int SW  = $clog2(SERIES_TERMS + 1);
    localparam int KW  = (CW > SW) ? CW : SW;
    localparam int DCW = $clog2(DIV_CYCLES);

    localparam logic [PW-1:0] ONE_Q40 = PW'(1) << FRAC_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [TOL_W-1:0]    r_tol, n_tol;
    logic [UW-1:0]       r_rate, n_rate;
    logic [FRAC_W-1:0]   r_target, n_target;   // CDF target, Q0.40
    logic                r_run, n_run;         // uniform above tolerance
    logic [PW-1:0]       r_val, n_val;         // series term, then p
    logic [PW-1:0]       r_sum, n_sum;         // series sum, then total
    logic [LOW_W-1:0]    r_lo_part, n_lo_part; // shifted low partial product
    logic [PW-1:0]       r_quo, n_quo;         // dividend in, quotient out
    logic [KW-1:0]       r_rem, n_rem;
    logic [DCW-1:0]      r_dcnt, n_dcnt;
    logic [KW-1:0]       r_k, n_k;
    logic [SQ_W-1:0]     r_sq, n_sq;
    logic                r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_sat, n_sat;

    // Control decodes
    logic in_acc;
    logic out_load;
    logic check_done;
    logic sq_last;
    logic div_last;
    logic ser_last;

    // ---------------------------------------------------------------
    // Shared multiplier. A x B_lo in S_MUL_LO, A x B_hi + registered low
    // part in S_MUL_HI.
    // ---------------------------------------------------------------
    logic [PW-1:0]     mul_a;
    logic [BW-1:0]     b_lo, b_hi, mul_b;
    logic [PRODW-1:0]  prod;
    logic [LOW_W-1:0]  lo_part;
    logic [PRODW:0]    hi_sum;
    logic [PW-1:0]     mul_res;

    always_comb begin
        mul_a = (r_phase == PH_SQUARE) ? r_sum : r_val;
        if (r_phase == PH_SQUARE) begin
            b_lo = BW'(r_sum[SQ_SPLIT-1:0]);
            b_hi = r_sum[FRAC_W:SQ_SPLIT];
        end else begin
            b_lo = BW'(r_rate[RATE_SPLIT-1:0]);
            b_hi = BW'(r_rate[UW-1:RATE_SPLIT]);
        end
        mul_b = (r_state == S_MUL_HI) ? b_hi : b_lo;
    end

    assign prod = PRODW'(mul_a) * PRODW'(mul_b);

    always_comb begin
        if (r_phase == PH_SQUARE) begin
            lo_part = LOW_W'(prod >> SQ_SPLIT);
        end else begin
            lo_part = LOW_W'(prod >> RATE_SPLIT);
        end
        hi_sum = (PRODW+1)'(prod) + (PRODW+1)'(r_lo_part);
        case (r_phase)
            PH_SQUARE: mul_res = PW'(hi_sum >> SQ_SHIFT);
            PH_STEP:   mul_res = PW'(hi_sum >> STEP_SHIFT);
            default:   mul_res = PW'(hi_sum >> SER_SHIFT);
        endcase
    end

    // ---------------------------------------------------------------
    // Restoring divider, DIV_STEP bits per cycle, divisor is k
    // ---------------------------------------------------------------
    logic [PW-1:0] div_quo;
    logic [KW-1:0] div_rem;

    always_comb begin : p_div
        logic [KW:0] trial;
        div_quo = r_quo;
        div_rem = r_rem;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial   = {div_rem, div_quo[PW-1]};
            div_quo = {div_quo[PW-2:0], 1'b0};
            if (trial >= {1'b0, r_k}) begin
                div_rem    = KW'(trial - {1'b0, r_k});
                div_quo[0] = 1'b1;
            end else begin
                div_rem = trial[KW-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign sq_last    = (r_sq == SQ_W'(SQUARINGS - 1));
    assign div_last   = (r_dcnt == DCW'(DIV_CYCLES - 1));
    assign ser_last   = (r_k == KW'(SERIES_TERMS));
    assign check_done = !r_run || (r_sum >= PW'(r_target)) || (r_k == KW'(MAX_COUNT));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                if (r_phase != PH_SQUARE) begin
                    n_state = S_DIV;
                end else if (sq_last) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_DIV: begin
                if (div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = (r_phase == PH_SERIES) ? S_MUL_LO : S_CHECK;
            end
            S_CHECK: begin
                n_state = check_done ? S_FINISH : S_MUL_LO;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        in_acc      = i_in_valid && (r_state == S_IDLE);
        out_load    = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_tol     = i_cfg_valid ? i_cfg_tolerance : r_tol;
        n_rate    = r_rate;
        n_target  = r_target;
        n_run     = r_run;
        n_val     = r_val;
        n_sum     = r_sum;
        n_lo_part = r_lo_part;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_k       = r_k;
        n_sq      = r_sq;
        n_count   = r_count;
        n_sat     = r_sat;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rate   = i_rate;
                    n_run    = i_uniform_value > UW'(r_tol);
                    n_target = {UW'(i_uniform_value - UW'(r_tol)), TGT_SHIFT'(0)};
                    n_val    = ONE_Q40;
                    n_sum    = ONE_Q40;
                    n_k      = KW'(1);
                    n_sq     = '0;
                    n_phase  = PH_SERIES;
                end
            end
            S_MUL_LO: begin
                n_lo_part = lo_part;
            end
            S_MUL_HI: begin
                if (r_phase == PH_SQUARE) begin
                    n_sum = mul_res;
                    n_val = mul_res;
                    n_sq  = SQ_W'(r_sq + 1'b1);
                    if (sq_last) begin
                        // p = total = exp(-rate), start the CDF walk
                        n_k     = '0;
                        n_phase = PH_STEP;
                    end
                end else begin
                    n_quo  = mul_res;
                    n_rem  = '0;
                    n_dcnt = '0;
                end
            end
            S_DIV: begin
                n_quo  = div_quo;
                n_rem  = div_rem;
                n_dcnt = DCW'(r_dcnt + 1'b1);
            end
            S_ACC: begin
                n_val = r_quo;
                if (r_phase == PH_SERIES) begin
                    // odd terms subtract (clamped at zero), even terms add
                    if (r_k[0]) begin
                        n_sum = (r_sum >= r_quo) ? r_sum - r_quo : '0;
                    end else begin
                        n_sum = r_sum + r_quo;
                    end
                    if (ser_last) begin
                        n_phase = PH_SQUARE;
                        n_sq    = '0;
                    end else begin
                        n_k = KW'(r_k + 1'b1);
                    end
                end else begin
                    n_sum = r_sum + r_quo;
                end
            end
            S_CHECK: begin
                if (!check_done) begin
                    n_k = KW'(r_k + 1'b1);
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_count = COUNT_W'(r_k);
                    // limit hit only counts when the CDF still fell short
                    n_sat   = r_run && (r_sum < PW'(r_target));
                end
            end
            default: ;
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SERIES;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_tol       <= n_tol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate    <= n_rate;
        r_target  <= n_target;
        r_run     <= n_run;
        r_val     <= n_val;
        r_sum     <= n_sum;
        r_lo_part <= n_lo_part;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dcnt    <= n_dcnt;
        r_k       <= n_k;
        r_sq      <= n_sq;
        r_count   <= n_count;
        r_sat     <= n_sat;
    end

    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;
    assign o_saturated = r_sat;

endmodule

FILE: rtl/pis_checker.sv
// pis_checker: port-level assertions for poisson_inversion_sampler,
// bound to the top level at the end of this file.
// Depends on pis_pkg.
module pis_checker #(
    parameter int unsigned MAX_COUNT = pis_pkg::MAX_COUNT_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [pis_pkg::UW-1:0]      i_uniform_value,
    input logic [pis_pkg::UW-1:0]      i_rate,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [pis_pkg::COUNT_W-1:0] o_count,
    input logic                        o_saturated
);
    import pis_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // one word in flight: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready right after an accepted word");

    // offered input word holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_uniform_value) && $stable(i_rate))
        else $error("input word changed while waiting");

    // saturation only at the count limit
    a_sat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_count == COUNT_W'(MAX_COUNT))
        else $error("saturated result with count off the limit");

    // a fresh result comes out of the busy phase, never straight from idle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while input side was idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_count) && $stable(o_saturated))
        else $error("result word changed while stalled");

endmodule

bind poisson_inversion_sampler pis_checker #(.MAX_COUNT(MAX_COUNT)) u_pis_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_uniform_value (i_uniform_value),
    .i_rate          (i_rate),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_count         (o_count),
    .o_saturated     (o_saturated)
);
